FILE: sv/vertex_transform_perspective_divide_core_macros.svh
// Assertion helpers for the top-level core, which checks its own logic.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_MACROS_SVH

`define VTPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define VTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/vtpd_pkg.sv
package vtpd_pkg;

  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int LANES       = 3;
  localparam int CLIP_W      = 66;
  localparam int MAG_W       = 65;
  localparam int FRAC_W      = 16;
  localparam int NUM_W       = MAG_W + FRAC_W;
  localparam int QW          = 33;
  localparam int TW          = MAG_W + QW;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [NUM_REGS-1:0][CFG_DATA_W-1:0] CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef logic signed [31:0] coef_t;
  typedef coef_t [3:0][3:0] mat_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] ndc_x;
    logic signed [31:0] ndc_y;
    logic signed [31:0] ndc_z;
    logic               w_zero;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [MAG_W-1:0]            den;
    logic [LANES-1:0]            neg;
    logic                        w_zero;
  } job_t;

endpackage

FILE: sv/vtpd_front.sv
module vtpd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  vtpd_pkg::mat_t mat,
  input  logic           in_valid,
  output logic           in_stall,
  input  vtpd_pkg::in_t  in_data,
  output logic           push,
  input  logic           full,
  output vtpd_pkg::job_t job
);
  import vtpd_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  in_t  pt_r;
  logic signed [3:0][2:0][63:0] prod_r;
  logic signed [3:0][63:0]      wterm_r;
  logic signed [3:0][CLIP_W-1:0] clip_r;
  logic signed [2:0][31:0] pv;
  logic [MAG_W-1:0] mag [LANES];
  logic [CLIP_W-1:0] neg3;

  assign adv3     = !v3_r || !full;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign push     = v3_r && !full;

  assign pv[0] = pt_r.point_x;
  assign pv[1] = pt_r.point_y;
  assign pv[2] = pt_r.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) pt_r <= in_data;
    if (adv2) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(mat[r][c]) * $signed(pv[c]);
        end
        wterm_r[r] <= {{16{mat[r][3][31]}}, mat[r][3], 16'h0};
      end
    end
    if (adv3) begin
      for (int r = 0; r < 4; r++) begin
        clip_r[r] <= CLIP_W'($signed(prod_r[r][0])) + CLIP_W'($signed(prod_r[r][1]))
                   + CLIP_W'($signed(prod_r[r][2])) + CLIP_W'($signed(wterm_r[r]));
      end
    end
  end

  assign neg3 = -clip_r[3];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = clip_r[l][CLIP_W-1] ? MAG_W'(-clip_r[l]) : MAG_W'(clip_r[l]);
      job.num[l] = {mag[l], {FRAC_W{1'b0}}};
      job.neg[l] = clip_r[l][CLIP_W-1] ^ clip_r[3][CLIP_W-1];
    end
    job.den    = clip_r[3][CLIP_W-1] ? neg3[MAG_W-1:0] : clip_r[3][MAG_W-1:0];
    job.w_zero = (clip_r[3] == '0);
  end

endmodule

FILE: sv/vtpd_queue.sv
module vtpd_queue #(
  parameter int DEPTH = vtpd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  vtpd_pkg::job_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output vtpd_pkg::job_t rd_data
);
  import vtpd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: sv/vtpd_back.sv
module vtpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_valid,
  output logic           rd_en,
  input  vtpd_pkg::job_t rd_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vtpd_pkg::out_t out_data
);
  import vtpd_pkg::*;

  localparam int NSTG = QW + 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   adv;
  logic [LANES-1:0][NUM_W-1:0] rem_r [NSTG];
  logic [LANES-1:0][QW-1:0]    q_r   [NSTG];
  logic [MAG_W-1:0]            den_r [NSTG];
  logic [LANES-1:0]            neg_r [NSTG];
  logic [LANES-1:0]            ovf_r [NSTG];
  logic                        wz_r  [NSTG];
  logic  out_v_r;
  out_t  out_r;
  logic [LANES-1:0][31:0] res;
  logic [LANES-1:0]       lane_sat;
  logic [QW-1:0]          limit [LANES];
  logic [QW-1:0]          mag   [LANES];

  assign adv[NSTG] = !out_v_r || !out_stall;
  assign rd_en     = rd_valid && adv[0];
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_stage
      assign adv[k] = !v_r[k] || adv[k+1];
      if (k == 0) begin : g_load
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= rd_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (adv[k]) begin
            rem_r[k] <= rd_data.num;
            q_r[k]   <= '0;
            den_r[k] <= rd_data.den;
            neg_r[k] <= rd_data.neg;
            wz_r[k]  <= rd_data.w_zero;
            for (int l = 0; l < LANES; l++) begin
              ovf_r[k][l] <= (TW'(rd_data.num[l]) >= (TW'(rd_data.den) << QW));
            end
          end
        end
      end else begin : g_bit
        logic [TW-1:0] trial;
        assign trial = TW'(den_r[k-1]) << (QW - k);
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= v_r[k-1];
          end
        end
        always_ff @(posedge clk) begin
          if (adv[k]) begin
            den_r[k] <= den_r[k-1];
            neg_r[k] <= neg_r[k-1];
            wz_r[k]  <= wz_r[k-1];
            ovf_r[k] <= ovf_r[k-1];
            for (int l = 0; l < LANES; l++) begin
              if (TW'(rem_r[k-1][l]) >= trial) begin
                rem_r[k][l] <= NUM_W'(TW'(rem_r[k-1][l]) - trial);
                q_r[k][l]   <= {q_r[k-1][l][QW-2:0], 1'b1};
              end else begin
                rem_r[k][l] <= rem_r[k-1][l];
                q_r[k][l]   <= {q_r[k-1][l][QW-2:0], 1'b0};
              end
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      limit[l]    = neg_r[NSTG-1][l] ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
      lane_sat[l] = ovf_r[NSTG-1][l] || (q_r[NSTG-1][l] > limit[l]);
      mag[l]      = lane_sat[l] ? limit[l] : q_r[NSTG-1][l];
      res[l]      = neg_r[NSTG-1][l] ? (32'h0 - mag[l][31:0]) : mag[l][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv[NSTG]) begin
      out_v_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      if (wz_r[NSTG-1]) begin
        out_r <= '{ndc_x: '0, ndc_y: '0, ndc_z: '0, w_zero: 1'b1, saturated: 1'b0};
      end else begin
        out_r <= '{ndc_x: res[0], ndc_y: res[1], ndc_z: res[2], w_zero: 1'b0,
                   saturated: |lane_sat};
      end
    end
  end

endmodule

FILE: sv/vertex_transform_perspective_divide_core.sv
// Transforms one point per item by a 4x4 Q16.16 matrix (w taken as 1.0) and
// divides clip x, y and z by clip w, giving saturated Q16.16 results.
// The input channel (in_valid, in_stall, in_data) takes one item per cycle
// whenever in_stall is low; the result channel (out_valid, out_stall,
// out_data) delivers one result item per input item, in order.
// The matrix sits in eight 64-bit registers written through cfg_valid,
// cfg_ready, cfg_index and cfg_data; cfg_ready is always high, indexes above
// seven are ignored, and the matrix must only change while no item is in flight.
// From input acceptance to out_valid an item passes through three front stages
// (input register, multipliers, adder tree), the queue, a 33-stage
// restoring divider that settles one quotient bit per stage after an overflow
// precheck stage, and the output register.
// Throughput is one item per cycle while out_stall is low, with a pipelined divider.
// When out_stall is high the result holds and the pipeline fills up; the
// queue between front and divider absorbs items until in_stall rises.
// Synchronous reset empties the pipeline and queue and loads the identity matrix.
`include "vertex_transform_perspective_divide_core_macros.svh"

module vertex_transform_perspective_divide_core #(
  parameter int QUEUE_DEPTH = vtpd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vtpd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vtpd_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vtpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vtpd_pkg::*;

  logic [NUM_REGS-1:0][CFG_DATA_W-1:0] regs_r;
  mat_t mat;
  logic push, full, rd_valid, rd_en;
  job_t job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      regs_r[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs_r[2*r][31:0];
      mat[r][1] = regs_r[2*r][63:32];
      mat[r][2] = regs_r[2*r+1][31:0];
      mat[r][3] = regs_r[2*r+1][63:32];
    end
  end

  vtpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mat      (mat),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .job      (job_in)
  );

  vtpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (job_in),
    .full     (full),
    .rd_valid (rd_valid),
    .rd_en    (rd_en),
    .rd_data  (job_out)
  );

  vtpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_en     (rd_en),
    .rd_data   (job_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `VTPD_ASSERT_SAME(a_no_push_full, push, !full, "push into a full queue")
  `VTPD_ASSERT_SAME(a_wzero_clean, out_valid && out_data.w_zero, !out_data.saturated && out_data.ndc_x == 32'sd0 && out_data.ndc_y == 32'sd0 && out_data.ndc_z == 32'sd0, "zero w result not cleared")
  `VTPD_ASSERT_SAME(a_sat_extreme, out_valid && out_data.saturated, out_data.ndc_x == 32'h7FFF_FFFF || out_data.ndc_x == 32'h8000_0000 || out_data.ndc_y == 32'h7FFF_FFFF || out_data.ndc_y == 32'h8000_0000 || out_data.ndc_z == 32'h7FFF_FFFF || out_data.ndc_z == 32'h8000_0000, "saturated flag without a clamped field")

endmodule

FILE: tb/vertex_transform_perspective_divide_core_test.sv
module vertex_transform_perspective_divide_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vtpd_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
    ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
  } mat_reg_e;

  localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX = 8'd200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  coef_t matrix [4][4];
  out_t expected_ndc [$];
  out_t want;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  vertex_transform_perspective_divide_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_t project_point(in_t p);
    logic signed [31:0] v [4];
    logic signed [67:0] clip [4];
    logic signed [99:0] num;
    logic signed [99:0] den;
    logic signed [99:0] q;
    logic [31:0] lane_val [3];
    out_t r;
    v[0] = p.point_x;
    v[1] = p.point_y;
    v[2] = p.point_z;
    v[3] = 32'sh0001_0000;
    r = '0;
    for (int row = 0; row < 4; row++) begin
      clip[row] = '0;
      for (int c = 0; c < 4; c++) begin
        clip[row] = clip[row] + (longint'(matrix[row][c]) * longint'(v[c]));
      end
    end
    if (clip[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    den = clip[3];
    for (int lane = 0; lane < 3; lane++) begin
      num = clip[lane];
      num = num <<< 16;
      q = num / den;
      if (q > 100'sh7FFF_FFFF) begin
        lane_val[lane] = 32'h7FFF_FFFF;
        r.saturated = 1'b1;
      end else if (q < -100'sh8000_0000) begin
        lane_val[lane] = 32'h8000_0000;
        r.saturated = 1'b1;
      end else begin
        lane_val[lane] = q[31:0];
      end
    end
    r.ndc_x = lane_val[0];
    r.ndc_y = lane_val[1];
    r.ndc_z = lane_val[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ndc.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_data.ndc_x), '0);
      end else begin
        want = expected_ndc.pop_front();
        if (out_data.ndc_x !== want.ndc_x) report_mismatch("ndc_x", out_data.ndc_x, want.ndc_x);
        if (out_data.ndc_y !== want.ndc_y) report_mismatch("ndc_y", out_data.ndc_y, want.ndc_y);
        if (out_data.ndc_z !== want.ndc_z) report_mismatch("ndc_z", out_data.ndc_z, want.ndc_z);
        if (out_data.w_zero !== want.w_zero)
          report_mismatch("w_zero", 32'(out_data.w_zero), 32'(want.w_zero));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_point(in_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (in_stall);
    expected_ndc.push_back(project_point(p));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    wait (expected_ndc.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) begin
      matrix[idx / 2][(idx % 2) * 2] = data[31:0];
      matrix[idx / 2][(idx % 2) * 2 + 1] = data[63:32];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_row(int row, logic [31:0] c0, logic [31:0] c1,
                          logic [31:0] c2, logic [31:0] c3);
    write_reg(mat_reg_e'(row * 2 + ROW0_COLS01), {c1, c0});
    write_reg(mat_reg_e'(row * 2 + ROW0_COLS23), {c3, c2});
  endtask

  function automatic logic [31:0] small_q(int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_t random_point();
    in_t p;
    if ($urandom_range(9) < 7) begin
      p.point_x = small_q(1 << 20);
      p.point_y = small_q(1 << 20);
      p.point_z = small_q(1 << 20);
    end else begin
      p.point_x = $urandom;
      p.point_y = $urandom;
      p.point_z = $urandom;
    end
    return p;
  endfunction

  task automatic load_random_matrix(int style);
    for (int row = 0; row < 4; row++) begin
      case (style)
        0: begin
          load_row(row, $urandom, $urandom, $urandom, $urandom);
        end
        1: begin
          load_row(row, small_q(1 << 17), small_q(1 << 17), small_q(1 << 17),
                   (row == 3) ? 32'(int'($urandom_range(1, 1 << 20))) : small_q(1 << 17));
        end
        default: begin
          load_row(row, $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                   $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                   $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                   $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    in_t p;
    logic [31:0] edges [6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
    for (int i = 0; i < 6; i++) begin
      p = '{edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]};
      send_point(p);
    end
    wait_idle();
    load_row(3, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1});
    send_point('{32'h0, 32'h0, 32'h0});
    wait_idle();
    load_row(3, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_point('{32'h0003_0000, 32'hFFFD_0000, 32'h0});
    send_point('{32'h0003_0000, 32'hFFFD_0000, 32'hFFFE_0000});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001});
    wait_idle();
    load_row(3, 32'h0, 32'h0, 32'h0, 32'h1);
    send_point('{32'h0001_0000, 32'hFFFF_0000, 32'h0});
    send_point('{32'h0, 32'h1, 32'hFFFF_FFFF});
    wait_idle();
    load_row(3, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000});
    wait_idle();
    write_reg(UNUSED_INDEX, {$urandom, $urandom});
    for (int row = 0; row < 4; row++) begin
      load_row(row, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    end
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    wait_idle();
    for (int row = 0; row < 4; row++) begin
      load_row(row, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    end
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0});
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    wait_idle();
  endtask

  task automatic test_random();
    int idle_modes [5] = '{0, 80, 0, 7, 0};
    int stall_modes [5] = '{0, 0, 80, 7, 0};
    int styles [5] = '{1, 0, 1, 2, 1};
    for (int ph = 0; ph < 5; ph++) begin
      load_random_matrix(styles[ph]);
      send_idle_pct = idle_modes[ph];
      stall_pct = stall_modes[ph];
      for (int n = 0; n < 260; n++) send_point(random_point());
      wait_idle();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    load_random_matrix(1);
    hold_cycles = 300;
    for (int n = 0; n < 80; n++) send_point(random_point());
    wait_idle();
  endtask

  initial begin
    for (int r = 0; r < NUM_REGS; r++) begin
      matrix[r / 2][(r % 2) * 2] = CFG_RESET[r][31:0];
      matrix[r / 2][(r % 2) * 2 + 1] = CFG_RESET[r][63:32];
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
